// File: hw/rtl/lvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lvs_pkg
// Shared types and constants for the loop-aware LRU victim selector.
// ----------------------------------------------------------------------------
package lvs_pkg;

  localparam int DEF_WAYS = 8;   // default associativity
  localparam int MASK_W   = 8;   // width of the per-way masks on the port
  localparam int WAY_W    = 3;   // width of way fields on the ports
  localparam int RANK_W   = 3;   // width of the reported rank
  localparam int ATT_W    = 4;   // width of the attempt register
  localparam int USED_W   = 3;   // width of the reported attempt number
  localparam int REJ_W    = 4;   // width of the reject count
  localparam int DATA_W   = 32;  // configuration data width
  localparam int PADDR_W  = 3;   // configuration address width

  localparam logic [ATT_W-1:0] QBS_RESET = 4'd1;
  localparam logic [ATT_W-1:0] QBS_MIN   = 4'd1;
  localparam logic [ATT_W-1:0] QBS_MAX   = 4'd8;

  // Register index, taken from paddr above the byte offset
  localparam logic REG_QBS_ATTEMPTS = 1'b0;

  typedef enum logic [1:0] {
    OPC_TOUCH  = 2'd0,
    OPC_VICTIM = 2'd1,
    OPC_FLAG   = 2'd2,
    OPC_NONE   = 2'd3
  } opcode_t;

  // Classified operation as it travels through the queue
  typedef enum logic [1:0] {
    KIND_NOP    = 2'd0,
    KIND_TOUCH  = 2'd1,
    KIND_VICTIM = 2'd2,
    KIND_FLAG   = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    VK_NONE    = 2'd0,
    VK_INVALID = 2'd1,
    VK_NONLOOP = 2'd2,
    VK_ANY     = 2'd3
  } vkind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_SCAN = 2'd2,
    ST_DONE = 2'd3
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/lvs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lvs_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lvs_front
  import lvs_pkg::*;
#(
  parameter int WAYS = DEF_WAYS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_opcode,
  input  wire logic [WAY_W-1:0]       in_way,
  input  wire logic                   in_loop_flag,
  input  wire logic [MASK_W-1:0]      in_valid_mask,
  input  wire logic [MASK_W-1:0]      in_replaceable_mask,
  input  wire logic [MASK_W-1:0]      in_lower_level_mask,
  output logic                        q_valid,
  output logic [$bits(op_kind_t)+$clog2(WAYS)+1+3*WAYS-1:0] q_item,
  input  wire logic                   q_pop
);

  localparam int WIDX   = $clog2(WAYS);
  localparam int ITEM_W = $bits(op_kind_t) + WIDX + 1 + 3 * WAYS;

  typedef struct packed {
    op_kind_t          kind;
    logic [WIDX-1:0]   way;
    logic              flag;
    logic [WAYS-1:0]   valid;
    logic [WAYS-1:0]   repl;
    logic [WAYS-1:0]   lower;
  } item_t;

  item_t                    item_c;
  logic [WIDX+WAY_W-1:0]    way_wide;
  logic                     way_ok;
  logic [WAYS+MASK_W-1:0]   valid_pad;
  logic [WAYS+MASK_W-1:0]   repl_pad;
  logic [WAYS+MASK_W-1:0]   lower_pad;

  item_t                    mem_r [2];
  logic                     wr_ptr_r, wr_ptr_nxt;
  logic                     rd_ptr_r, rd_ptr_nxt;
  logic [1:0]               count_r, count_nxt;
  logic                     push;

  // Ways past the port's mask width see zero mask bits.
  assign way_wide  = {{WIDX{1'b0}}, in_way};
  assign way_ok    = way_wide < (WIDX + WAY_W)'(WAYS);
  assign valid_pad = {{WAYS{1'b0}}, in_valid_mask};
  assign repl_pad  = {{WAYS{1'b0}}, in_replaceable_mask};
  assign lower_pad = {{WAYS{1'b0}}, in_lower_level_mask};

  always_comb begin
    item_c.way   = way_wide[WIDX-1:0];
    item_c.flag  = in_loop_flag;
    item_c.valid = valid_pad[WAYS-1:0];
    item_c.repl  = repl_pad[WAYS-1:0];
    item_c.lower = lower_pad[WAYS-1:0];
    case (opcode_t'(in_opcode))
      OPC_TOUCH:  item_c.kind = way_ok ? KIND_TOUCH : KIND_NOP;
      OPC_VICTIM: item_c.kind = KIND_VICTIM;
      OPC_FLAG:   item_c.kind = way_ok ? KIND_FLAG : KIND_NOP;
      default:    item_c.kind = KIND_NOP;
    endcase
  end

  assign in_stall = count_r == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = count_r != 2'd0;
  assign q_item   = ITEM_W'(mem_r[rd_ptr_r]);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_c;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lvs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lvs_back
// Sequencer that holds the recency ranks and loop flags and carries out
// touches, loop-flag writes and victim selection, one attempt per cycle.
// ----------------------------------------------------------------------------
module lvs_back
  import lvs_pkg::*;
#(
  parameter int WAYS = DEF_WAYS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire logic [$bits(op_kind_t)+$clog2(WAYS)+1+3*WAYS-1:0] q_item,
  output logic                        q_pop,
  input  wire logic [ATT_W-1:0]       qbs_attempts,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [WAY_W-1:0]            out_victim_way,
  output logic [1:0]                  out_victim_kind,
  output logic [RANK_W-1:0]           out_prior_rank,
  output logic [USED_W-1:0]           out_attempt_used,
  output logic [REJ_W-1:0]            out_qbs_rejects
);

  localparam int WIDX = $clog2(WAYS);

  typedef struct packed {
    op_kind_t          kind;
    logic [WIDX-1:0]   way;
    logic              flag;
    logic [WAYS-1:0]   valid;
    logic [WAYS-1:0]   repl;
    logic [WAYS-1:0]   lower;
  } item_t;

  state_t               state_r, state_nxt;
  item_t                item_r, item_nxt;
  logic [WIDX-1:0]      rank_r [WAYS];
  logic [WIDX-1:0]      rank_nxt [WAYS];
  logic [WAYS-1:0]      marks_r, marks_nxt;
  logic                 phase_r, phase_nxt;
  logic [USED_W-1:0]    attempt_r, attempt_nxt;
  logic [REJ_W-1:0]     rejects_r, rejects_nxt;

  logic [WIDX-1:0]      res_way_r, res_way_nxt;
  vkind_t               res_kind_r, res_kind_nxt;
  logic [WIDX-1:0]      res_prior_r, res_prior_nxt;
  logic [USED_W-1:0]    res_used_r, res_used_nxt;
  logic [REJ_W-1:0]     res_rej_r, res_rej_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [WAY_W-1:0]     out_way_r;
  vkind_t               out_kind_r;
  logic [RANK_W-1:0]    out_prior_r;
  logic [USED_W-1:0]    out_used_r;
  logic [REJ_W-1:0]     out_rej_r;
  logic                 out_free;
  logic                 out_load;

  logic [ATT_W-1:0]     tries;
  logic [WAYS-1:0]      inval;
  logic                 any_inval;
  logic [WIDX-1:0]      inval_idx;
  logic [WAYS-1:0]      elig;
  logic [WAYS-1:0]      is_old;
  logic                 found;
  logic [WIDX-1:0]      cand;
  logic [WIDX-1:0]      w_sel;
  logic                 lower_hit;
  logic                 scan_fall;
  logic                 scan_take;
  logic                 mru_en;
  logic [WIDX-1:0]      mru_way;
  logic [WIDX+WAY_W-1:0] way_pad;
  logic [WIDX+RANK_W-1:0] prior_pad;

  // Attempt register clamped to one through eight
  always_comb begin
    if (qbs_attempts < QBS_MIN) begin
      tries = QBS_MIN;
    end else if (qbs_attempts > QBS_MAX) begin
      tries = QBS_MAX;
    end else begin
      tries = qbs_attempts;
    end
  end

  // Lowest-numbered invalid way
  always_comb begin
    inval     = ~item_r.valid;
    any_inval = |inval;
    inval_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (inval[i]) begin
        inval_idx = WIDX'(i);
      end
    end
  end

  // Oldest eligible way: ranks form a permutation, so the oldest is the one
  // that no other eligible way outranks. Rank zero is never a candidate.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      elig[i] = item_r.repl[i] && (rank_r[i] != '0) && !(!phase_r && marks_r[i]);
    end
    for (int i = 0; i < WAYS; i++) begin
      is_old[i] = elig[i];
      for (int j = 0; j < WAYS; j++) begin
        if (elig[j] && (rank_r[j] > rank_r[i])) begin
          is_old[i] = 1'b0;
        end
      end
    end
    found = |is_old;
    cand  = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (is_old[i]) begin
        cand = cand | WIDX'(i);
      end
    end
  end

  assign w_sel     = found ? cand : '0;
  assign lower_hit = (({1'b0, attempt_r} + ATT_W'(1)) < tries) && item_r.lower[w_sel];
  assign scan_fall = !found && !phase_r;
  assign scan_take = !scan_fall && !lower_hit;

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_DONE) && out_free;

  // Next state
  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = q_valid ? ST_RUN : ST_IDLE;
      ST_RUN:  state_nxt = (item_r.kind == KIND_VICTIM && !any_inval) ? ST_SCAN : ST_DONE;
      ST_SCAN: state_nxt = scan_take ? ST_DONE : ST_SCAN;
      ST_DONE: state_nxt = out_free ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls and result registers
  always_comb begin
    q_pop         = 1'b0;
    item_nxt      = item_r;
    marks_nxt     = marks_r;
    phase_nxt     = phase_r;
    attempt_nxt   = attempt_r;
    rejects_nxt   = rejects_r;
    res_way_nxt   = res_way_r;
    res_kind_nxt  = res_kind_r;
    res_prior_nxt = res_prior_r;
    res_used_nxt  = res_used_r;
    res_rej_nxt   = res_rej_r;
    mru_en        = 1'b0;
    mru_way       = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = item_t'(q_item);
        end
      end
      ST_RUN: begin
        res_way_nxt   = '0;
        res_kind_nxt  = VK_NONE;
        res_prior_nxt = '0;
        res_used_nxt  = '0;
        res_rej_nxt   = '0;
        phase_nxt     = 1'b0;
        attempt_nxt   = '0;
        rejects_nxt   = '0;
        case (item_r.kind)
          KIND_TOUCH: begin
            res_prior_nxt = rank_r[item_r.way];
            mru_en        = 1'b1;
            mru_way       = item_r.way;
          end
          KIND_FLAG: begin
            marks_nxt[item_r.way] = item_r.flag;
          end
          KIND_VICTIM: begin
            if (any_inval) begin
              mru_en               = 1'b1;
              mru_way              = inval_idx;
              marks_nxt[inval_idx] = 1'b0;
              res_way_nxt          = inval_idx;
              res_kind_nxt         = VK_INVALID;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_fall) begin
          // Nothing left in the non-loop phase: retry with any kind of way.
          phase_nxt   = 1'b1;
          attempt_nxt = '0;
        end else begin
          mru_en  = 1'b1;
          mru_way = w_sel;
          if (lower_hit) begin
            rejects_nxt = rejects_r + REJ_W'(1);
            attempt_nxt = attempt_r + USED_W'(1);
          end else begin
            if (phase_r) begin
              marks_nxt[w_sel] = 1'b0;
            end
            res_way_nxt  = w_sel;
            res_kind_nxt = phase_r ? VK_ANY : VK_NONLOOP;
            res_used_nxt = attempt_r;
            res_rej_nxt  = rejects_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Move one way to most-recently-used
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rank_nxt[i] = rank_r[i];
      if (mru_en) begin
        if (WIDX'(i) == mru_way) begin
          rank_nxt[i] = '0;
        end else if (rank_r[i] < rank_r[mru_way]) begin
          rank_nxt[i] = rank_r[i] + WIDX'(1);
        end
      end
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign way_pad   = {{WAY_W{1'b0}}, res_way_r};
  assign prior_pad = {{RANK_W{1'b0}}, res_prior_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        rank_r[i] <= WIDX'(i);
      end
    end else begin
      state_r     <= state_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
      rank_r      <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    phase_r     <= phase_nxt;
    attempt_r   <= attempt_nxt;
    rejects_r   <= rejects_nxt;
    res_way_r   <= res_way_nxt;
    res_kind_r  <= res_kind_nxt;
    res_prior_r <= res_prior_nxt;
    res_used_r  <= res_used_nxt;
    res_rej_r   <= res_rej_nxt;
    if (out_load) begin
      out_way_r   <= way_pad[WAY_W-1:0];
      out_kind_r  <= res_kind_r;
      out_prior_r <= prior_pad[RANK_W-1:0];
      out_used_r  <= res_used_r;
      out_rej_r   <= res_rej_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_victim_way   = out_way_r;
  assign out_victim_kind  = out_kind_r;
  assign out_prior_rank   = out_prior_r;
  assign out_attempt_used = out_used_r;
  assign out_qbs_rejects  = out_rej_r;

endmodule
`default_nettype wire

// File: hw/rtl/loop_aware_lru_victim_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// loop_aware_lru_victim_select
// True-LRU replacement for one cache set with loop-aware, query-based victim
// selection.
// ----------------------------------------------------------------------------
// Each input beat yields exactly one result beat. Beats enter a two-entry
// queue and are carried out one at a time by a sequencer. A touch, a
// loop-flag write, an unused opcode or a victim request that finds an invalid
// way goes from the queue through the run and done states; done waits for a
// free output register. Other victim requests also pass the scan state, one
// selection attempt (rejected or accepted) at a time, plus a fallback when
// the non-loop phase finds no candidate; each attempt is one parallel
// oldest-way compare over all ways. A finished result waits in the output
// register while the queue keeps taking new beats until it is full.
// ----------------------------------------------------------------------------
module loop_aware_lru_victim_select
  import lvs_pkg::*;
#(
  parameter int WAYS = DEF_WAYS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [WAY_W-1:0]     in_way,
  input  wire logic                 in_loop_flag,
  input  wire logic [MASK_W-1:0]    in_valid_mask,
  input  wire logic [MASK_W-1:0]    in_replaceable_mask,
  input  wire logic [MASK_W-1:0]    in_lower_level_mask,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WAY_W-1:0]          out_victim_way,
  output logic [1:0]                out_victim_kind,
  output logic [RANK_W-1:0]         out_prior_rank,
  output logic [USED_W-1:0]         out_attempt_used,
  output logic [REJ_W-1:0]          out_qbs_rejects,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam int WIDX   = $clog2(WAYS);
  localparam int ITEM_W = $bits(op_kind_t) + WIDX + 1 + 3 * WAYS;

  logic                 q_valid;
  logic [ITEM_W-1:0]    q_item;
  logic                 q_pop;
  logic [ATT_W-1:0]     qbs_r, qbs_nxt;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1] == REG_QBS_ATTEMPTS;

  always_comb begin
    qbs_nxt = qbs_r;
    if (psel && penable && pwrite && reg_sel) begin
      qbs_nxt = pwdata[ATT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qbs_r <= QBS_RESET;
    end else begin
      qbs_r <= qbs_nxt;
    end
  end

  assign prdata = reg_sel ? {{(DATA_W - ATT_W){1'b0}}, qbs_r} : '0;

  lvs_front #(
    .WAYS (WAYS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_way              (in_way),
    .in_loop_flag        (in_loop_flag),
    .in_valid_mask       (in_valid_mask),
    .in_replaceable_mask (in_replaceable_mask),
    .in_lower_level_mask (in_lower_level_mask),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop)
  );

  lvs_back #(
    .WAYS (WAYS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .qbs_attempts     (qbs_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_victim_way   (out_victim_way),
    .out_victim_kind  (out_victim_kind),
    .out_prior_rank   (out_prior_rank),
    .out_attempt_used (out_attempt_used),
    .out_qbs_rejects  (out_qbs_rejects)
  );

endmodule
`default_nettype wire
